>>> src/pid_integral_separation_macros.svh
// Assertion macros shared by the verification code of the PID controller.
// They expect signals named clock and reset in the scope where they are used.
`ifndef PID_INTEGRAL_SEPARATION_MACROS_SVH
`define PID_INTEGRAL_SEPARATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pis_pkg.sv
// Types and constants of the PID controller with integral separation.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package pis_pkg;

   localparam int GAIN_W         = 16;
   localparam int MEAS_W         = 16;
   localparam int ERR_W          = MEAS_W + 1;
   localparam int DIFF_W         = ERR_W + 1;
   localparam int SUM_W          = 8;
   localparam int OUT_W          = 32;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 5;
   localparam int REG_IDX_W      = 3;

   localparam int INTEGRAL_LIMIT     = 100;
   localparam int SEPARATION_BOUND   = 3;
   localparam int GAIN_FRACTION_BITS = 8;
   localparam int OUT_FRAC_BITS      = 8;

   localparam int PKP_W  = GAIN_W + ERR_W;
   localparam int PKI_W  = GAIN_W + SUM_W;
   localparam int PKD_W  = GAIN_W + DIFF_W;
   localparam int RAW_W  = PKD_W + 2;
   localparam int SCL_W  = RAW_W + OUT_FRAC_BITS;
   localparam int SHIFT_RIGHT = (GAIN_FRACTION_BITS >= OUT_FRAC_BITS) ?
                                GAIN_FRACTION_BITS - OUT_FRAC_BITS : 0;
   localparam int SHIFT_LEFT  = (GAIN_FRACTION_BITS < OUT_FRAC_BITS) ?
                                OUT_FRAC_BITS - GAIN_FRACTION_BITS : 0;

   localparam logic signed [OUT_W-1:0] UPPER_RESET = 32'sh7FFF_FFFF;
   localparam logic signed [OUT_W-1:0] LOWER_RESET = 32'sh8000_0000;

   // Register indexes, byte address divided by four.
   localparam logic [REG_IDX_W-1:0] REG_KP_GAIN   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KI_GAIN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KD_GAIN   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SETPOINT  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OUT_UPPER = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OUT_LOWER = 3'd5;

   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic signed [SUM_W-1:0]  sum;
   } integ_type;

   typedef struct packed {
      logic signed [PKP_W-1:0] p_kp;
      logic signed [PKI_W-1:0] p_ki;
      logic signed [PKD_W-1:0] p_kd;
   } prod_type;

endpackage

>>> src/pid_integral_separation.sv
// Positional PID controller with integral separation: top level with the
// register port and pipeline control. Depends on pis_pkg, pis_integ, pis_mult, pis_sat.
`timescale 1ns / 1ps

// Each request transaction carries a measurement and a hold flag and yields
// exactly one response transaction with the saturated drive value (8
// fraction bits) and a flag that says it was clamped. The error is
// setpoint minus measurement; with hold clear the integral sum adds the
// error when its magnitude is below three and is cleared otherwise, and it
// is always kept within plus or minus the integral limit. The block is a
// three-stage pipeline: error and integral update, the three gain
// multipliers, then summing, scaling and saturation into the result
// register. A new request is taken every cycle while the consumer keeps up;
// stages that hold no data close up, so up to two further requests are
// still taken while a result waits for the consumer, after which the
// request side stalls until it is taken. The integral sum and error history
// advance when the request is taken, so one transaction per cycle is
// sustained. The user must write registers through the APB-style port only
// while no transaction is in flight; the block itself does not enforce it.

module pid_integral_separation
   import pis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [MEAS_W-1:0]     req_tdata,   // [15:0] measured
   input  logic [0:0]            req_tuser,   // [0] hold_integral
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,   // [31:0] drive
   output logic [0:0]            rsp_tuser,   // [0] limited
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic signed [GAIN_W-1:0] kp_gain_ff, ki_gain_ff, kd_gain_ff;
   logic [MEAS_W-1:0]        setpoint_ff;
   logic signed [OUT_W-1:0]  out_upper_ff, out_lower_ff;

   logic                 csr_write;
   logic [REG_IDX_W-1:0] reg_idx;

   // Stage valid flags: integral stage, multiplier stage, result register.
   logic      v1_ff, v2_ff, v3_ff;
   logic      en1, en2, en3;
   logic      accept;
   integ_type integ_q;
   prod_type  prod_q;
   logic      limited;

   // The register port never waits.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff   <= '0;
         ki_gain_ff   <= '0;
         kd_gain_ff   <= '0;
         setpoint_ff  <= '0;
         out_upper_ff <= UPPER_RESET;
         out_lower_ff <= LOWER_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_KP_GAIN:   kp_gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_KI_GAIN:   ki_gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_KD_GAIN:   kd_gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_SETPOINT:  setpoint_ff  <= csr_pwdata[MEAS_W-1:0];
            REG_OUT_UPPER: out_upper_ff <= csr_pwdata[OUT_W-1:0];
            REG_OUT_LOWER: out_lower_ff <= csr_pwdata[OUT_W-1:0];
            default: begin
               // Addresses beyond the register list are ignored.
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KP_GAIN:   csr_prdata = CSR_DATA_W'(unsigned'(kp_gain_ff));
         REG_KI_GAIN:   csr_prdata = CSR_DATA_W'(unsigned'(ki_gain_ff));
         REG_KD_GAIN:   csr_prdata = CSR_DATA_W'(unsigned'(kd_gain_ff));
         REG_SETPOINT:  csr_prdata = CSR_DATA_W'(setpoint_ff);
         REG_OUT_UPPER: csr_prdata = out_upper_ff;
         REG_OUT_LOWER: csr_prdata = out_lower_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // A stage loads when it is empty or when its contents move on.
   assign en3        = !v3_ff || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   pis_integ u_integ (
      .clock         (clock),
      .reset         (reset),
      .load          (en1),
      .accept        (accept),
      .setpoint      (setpoint_ff),
      .measured      (req_tdata),
      .hold_integral (req_tuser[0]),
      .stage_q       (integ_q)
   );

   pis_mult u_mult (
      .clock   (clock),
      .load    (en2),
      .kp_gain (kp_gain_ff),
      .ki_gain (ki_gain_ff),
      .kd_gain (kd_gain_ff),
      .stage_d (integ_q),
      .prod_q  (prod_q)
   );

   pis_sat u_sat (
      .clock     (clock),
      .load      (en3),
      .out_upper (out_upper_ff),
      .out_lower (out_lower_ff),
      .prod_d    (prod_q),
      .drive     (rsp_tdata),
      .limited   (limited)
   );

   assign rsp_tvalid   = v3_ff;
   assign rsp_tuser[0] = limited;

endmodule

>>> src/pis_integ.sv
// Error and integral stage: forms the error, updates the integral sum with
// separation and clamping, and keeps the error history. Depends on pis_pkg.
`timescale 1ns / 1ps

module pis_integ
   import pis_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    accept,
   input  logic [MEAS_W-1:0]       setpoint,
   input  logic [MEAS_W-1:0]       measured,
   input  logic                    hold_integral,
   output integ_type               stage_q
);

   localparam logic signed [SUM_W:0] LIMIT_POS = (SUM_W + 1)'(INTEGRAL_LIMIT);
   localparam logic signed [SUM_W:0] LIMIT_NEG = -(SUM_W + 1)'(INTEGRAL_LIMIT);
   localparam logic signed [ERR_W-1:0] BOUND_POS = ERR_W'(SEPARATION_BOUND);
   localparam logic signed [ERR_W-1:0] BOUND_NEG = -ERR_W'(SEPARATION_BOUND);

   logic signed [DIFF_W-1:0] last_error_ff;
   logic signed [SUM_W-1:0]  error_sum_ff;
   integ_type                stage_ff;

   logic signed [ERR_W-1:0]  err;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  error_sum_in;
   logic                     inside_band;
   integ_type                stage_in;

   always_comb begin
      err         = $signed({1'b0, setpoint}) - $signed({1'b0, measured});
      inside_band = (err > BOUND_NEG) && (err < BOUND_POS);
      if (hold_integral) begin
         sum_wide = (SUM_W + 1)'(error_sum_ff);
      end else if (inside_band) begin
         sum_wide = (SUM_W + 1)'(error_sum_ff) + $signed(err[SUM_W:0]);
      end else begin
         sum_wide = '0;
      end
      if (sum_wide > LIMIT_POS) begin
         error_sum_in = SUM_W'(LIMIT_POS);
      end else if (sum_wide < LIMIT_NEG) begin
         error_sum_in = SUM_W'(LIMIT_NEG);
      end else begin
         error_sum_in = sum_wide[SUM_W-1:0];
      end
      stage_in.err  = err;
      stage_in.diff = DIFF_W'(err) - last_error_ff;
      stage_in.sum  = error_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (accept) begin
         last_error_ff <= DIFF_W'(err);
         error_sum_ff  <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_q = stage_ff;

endmodule

>>> src/pis_mult.sv
// Gain stage: the three gain products, each registered.
// Depends on pis_pkg.
`timescale 1ns / 1ps

module pis_mult
   import pis_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [GAIN_W-1:0] kp_gain,
   input  logic signed [GAIN_W-1:0] ki_gain,
   input  logic signed [GAIN_W-1:0] kd_gain,
   input  integ_type                stage_d,
   output prod_type                 prod_q
);

   prod_type prod_ff;
   prod_type prod_in;

   always_comb begin
      prod_in.p_kp = kp_gain * stage_d.err;
      prod_in.p_ki = ki_gain * stage_d.sum;
      prod_in.p_kd = kd_gain * stage_d.diff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_q = prod_ff;

endmodule

>>> src/pis_sat.sv
// Output stage: sums the products, brings them to the output format and
// saturates against the limits into the result register. Depends on pis_pkg.
`timescale 1ns / 1ps

module pis_sat
   import pis_pkg::*;
(
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [OUT_W-1:0] out_upper,
   input  logic signed [OUT_W-1:0] out_lower,
   input  prod_type                prod_d,
   output logic [OUT_W-1:0]        drive,
   output logic                    limited
);

   logic [OUT_W-1:0] drive_ff, drive_in;
   logic             limited_ff, limited_in;

   logic signed [RAW_W-1:0] raw;
   logic signed [SCL_W-1:0] scaled;
   logic signed [SCL_W-1:0] after_upper;
   logic                    hit_upper;

   always_comb begin
      raw    = RAW_W'(prod_d.p_kp) + RAW_W'(prod_d.p_ki) + RAW_W'(prod_d.p_kd);
      // Arithmetic right shift rounds toward minus infinity.
      scaled = (SCL_W'(raw) <<< SHIFT_LEFT) >>> SHIFT_RIGHT;
      hit_upper   = scaled > SCL_W'(out_upper);
      after_upper = hit_upper ? SCL_W'(out_upper) : scaled;
      if (after_upper < SCL_W'(out_lower)) begin
         drive_in   = out_lower;
         limited_in = 1'b1;
      end else begin
         drive_in   = after_upper[OUT_W-1:0];
         limited_in = hit_upper;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff   <= drive_in;
         limited_ff <= limited_in;
      end
   end

   assign drive   = drive_ff;
   assign limited = limited_ff;

endmodule

>>> src/pis_checker.sv
// Port-level checks of the PID controller and the bind that attaches them.
// Depends on pis_pkg and pid_integral_separation_macros.svh.
`timescale 1ns / 1ps
`include "pid_integral_separation_macros.svh"

module pis_checker
   import pis_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_W-1:0]      rsp_tdata,
   input logic [0:0]            rsp_tuser,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic                  csr_pready
);

   // Copies of the output limits, followed from the register writes.
   logic signed [OUT_W-1:0] upper_ff, lower_ff;
   logic                    wr;

   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UPPER_RESET;
         lower_ff <= LOWER_RESET;
      end else if (wr && csr_paddr[CSR_ADDR_W-1:2] == REG_OUT_UPPER) begin
         upper_ff <= csr_pwdata[OUT_W-1:0];
      end else if (wr && csr_paddr[CSR_ADDR_W-1:2] == REG_OUT_LOWER) begin
         lower_ff <= csr_pwdata[OUT_W-1:0];
      end
   end

   `PIS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `PIS_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready,
      "request refused while the result register is empty")
   `PIS_ASSERT_NOW(a_above_lower, rsp_tvalid, $signed(rsp_tdata) >= lower_ff,
      "drive below the lower limit")
   `PIS_ASSERT_NOW(a_limited_value, rsp_tvalid && rsp_tuser[0],
      $signed(rsp_tdata) == upper_ff || $signed(rsp_tdata) == lower_ff,
      "limited drive is not a limit value")

endmodule

bind pid_integral_separation pis_checker u_pis_checker (.*);
